// File: rtl/epoch_to_calendar_date_core_defines.svh
// Assertion macros shared by the epoch to calendar date converter.
// No dependencies; included by the files that carry assertions.
`ifndef EPOCH_TO_CALENDAR_DATE_CORE_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define ECD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ECD_ASSERT_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ECD_ASSERT(label, prop, msg)

`define ECD_ASSERT_RESET(label, prop, msg)

`endif

`endif

// File: rtl/ecd_pkg.sv
// Package for the epoch to calendar date converter: constants, tables and types.
// No dependencies; used by every module of the converter.
package ecd_pkg;

   localparam int EPOCH_W        = 32;
   localparam int SECS_PER_MIN   = 60;
   localparam int MINS_PER_HOUR  = 60;
   localparam int HOURS_PER_DAY  = 24;
   localparam int DAYS_PER_CYCLE = 365 * 4 + 1;

   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 8;
   localparam int DIC_W   = $clog2(DAYS_PER_CYCLE);
   localparam int DOY_W   = 9;

   localparam logic [DIC_W-1:0] YEAR_START [4] = '{
      DIC_W'(0), DIC_W'(366), DIC_W'(731), DIC_W'(1096)
   };

   // Month starts in a common year; a leap year adds one from March on.
   localparam logic [DOY_W-1:0] MONTH_START [12] = '{
      DOY_W'(0),   DOY_W'(31),  DOY_W'(59),  DOY_W'(90),
      DOY_W'(120), DOY_W'(151), DOY_W'(181), DOY_W'(212),
      DOY_W'(243), DOY_W'(273), DOY_W'(304), DOY_W'(334)
   };

   typedef struct packed {
      logic [SEC_W-1:0]  second;
      logic [MIN_W-1:0]  minute;
      logic [HOUR_W-1:0] hour;
   } time_type;

   function automatic int quot_width(input int in_w, input int divisor);
      return in_w - $clog2(divisor) + 1;
   endfunction

endpackage

// File: rtl/ecd_div_const.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Depends on ecd_pkg for the time fields that travel alongside each item.
module ecd_div_const
   import ecd_pkg::*;
#(
   parameter int IN_W   = EPOCH_W,
   parameter int DIV    = SECS_PER_MIN,
   parameter int REM_W  = $clog2(DIV),
   parameter int QUOT_W = IN_W - REM_W + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [IN_W-1:0]   in_value,
   input  time_type          in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [QUOT_W-1:0] out_quot,
   output logic [REM_W-1:0]  out_rem,
   output time_type          out_side
);

   localparam int SHIFT = IN_W + REM_W - 1;
   localparam logic [IN_W-1:0] RECIP = IN_W'((64'd1 << SHIFT) / DIV);

   logic                s1_valid_ff, s1_valid_in;
   logic [IN_W-1:0]     s1_value_ff;
   logic [2*IN_W-1:0]   s1_prod_ff, s1_prod_in;
   time_type            s1_side_ff;
   logic                s2_valid_ff, s2_valid_in;
   logic [QUOT_W-1:0]   s2_quot_ff, s2_quot_in;
   logic [REM_W-1:0]    s2_rem_ff, s2_rem_in;
   time_type            s2_side_ff;
   logic                s1_ready, s2_ready;
   logic [QUOT_W-1:0]   quot_est;
   logic [IN_W-1:0]     back_prod;
   logic [IN_W-1:0]     rem_full;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = in_valid;
   assign s1_prod_in  = (2 * IN_W)'(in_value) * (2 * IN_W)'(RECIP);

   always_comb begin
      quot_est  = s1_prod_ff[SHIFT +: QUOT_W];
      back_prod = IN_W'(IN_W'(quot_est) * IN_W'(DIV));
      rem_full  = s1_value_ff - back_prod;
      if (rem_full >= IN_W'(DIV)) begin
         s2_quot_in = quot_est + QUOT_W'(1);
         s2_rem_in  = REM_W'(rem_full - IN_W'(DIV));
      end else begin
         s2_quot_in = quot_est;
         s2_rem_in  = REM_W'(rem_full);
      end
   end

   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_ready) begin
            s2_valid_ff <= s2_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_value_ff <= in_value;
         s1_prod_ff  <= s1_prod_in;
         s1_side_ff  <= in_side;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_quot_ff <= s2_quot_in;
         s2_rem_ff  <= s2_rem_in;
         s2_side_ff <= s1_side_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_quot  = s2_quot_ff;
   assign out_rem   = s2_rem_ff;
   assign out_side  = s2_side_ff;

endmodule

// File: rtl/ecd_calendar.sv
// Two-stage calendar lookup: year within the four-year cycle, then month and day.
// Depends on ecd_pkg for the year and month start tables.
module ecd_calendar
   import ecd_pkg::*;
#(
   parameter int CYCLE_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [CYCLE_W-1:0] in_cycles,
   input  logic [DIC_W-1:0]   in_day_in_cycle,
   input  time_type           in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output time_type           out_side,
   output logic [DAY_W-1:0]   out_day,
   output logic [MONTH_W-1:0] out_month,
   output logic [YEAR_W-1:0]  out_year
);

   logic               s1_valid_ff;
   logic [YEAR_W-1:0]  s1_year_ff, s1_year_in;
   logic [DOY_W-1:0]   s1_doy_ff, s1_doy_in;
   logic               s1_leap_ff, s1_leap_in;
   time_type           s1_side_ff;
   logic               s2_valid_ff;
   logic [DAY_W-1:0]   s2_day_ff, s2_day_in;
   logic [MONTH_W-1:0] s2_month_ff, s2_month_in;
   logic [YEAR_W-1:0]  s2_year_ff;
   time_type           s2_side_ff;
   logic               s1_ready, s2_ready;
   logic [1:0]         year_in_cycle;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      if (in_day_in_cycle >= YEAR_START[3]) begin
         year_in_cycle = 2'd3;
      end else if (in_day_in_cycle >= YEAR_START[2]) begin
         year_in_cycle = 2'd2;
      end else if (in_day_in_cycle >= YEAR_START[1]) begin
         year_in_cycle = 2'd1;
      end else begin
         year_in_cycle = 2'd0;
      end
      s1_doy_in  = DOY_W'(in_day_in_cycle - YEAR_START[year_in_cycle]);
      s1_leap_in = (year_in_cycle == 2'd0);
      s1_year_in = YEAR_W'({in_cycles, year_in_cycle});
   end

   always_comb begin
      logic [DOY_W-1:0] starts [12];
      logic [3:0]       month_idx;
      for (int i = 0; i < 12; i++) begin
         starts[i] = MONTH_START[i] + DOY_W'((s1_leap_ff && i >= 2) ? 1 : 0);
      end
      month_idx = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (s1_doy_ff >= starts[i]) begin
            month_idx = 4'(i);
         end
      end
      s2_month_in = MONTH_W'(month_idx + 4'd1);
      s2_day_in   = DAY_W'(s1_doy_ff - starts[month_idx] + DOY_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_year_ff <= s1_year_in;
         s1_doy_ff  <= s1_doy_in;
         s1_leap_ff <= s1_leap_in;
         s1_side_ff <= in_side;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_day_ff   <= s2_day_in;
         s2_month_ff <= s2_month_in;
         s2_year_ff  <= s1_year_ff;
         s2_side_ff  <= s1_side_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_side  = s2_side_ff;
   assign out_day   = s2_day_ff;
   assign out_month = s2_month_ff;
   assign out_year  = s2_year_ff;

endmodule

// File: rtl/epoch_to_calendar_date_core.sv
// Epoch to calendar date converter, top level; uses ecd_pkg, ecd_div_const and ecd_calendar.
// The path from an accepted item to its result runs through two stages for each of the
// four constant divisions (by 60, 60, 24 and 1461) and two for the calendar lookup.
// Throughput is one item per cycle; each stage holds its item while the next one is full.
// Synchronous reset empties the pipeline; no payload register is cleared.
`include "epoch_to_calendar_date_core_defines.svh"

module epoch_to_calendar_date_core
   import ecd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [EPOCH_W-1:0] req_epoch_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SEC_W-1:0]   rsp_second_of_minute,
   output logic [MIN_W-1:0]   rsp_minute_of_hour,
   output logic [HOUR_W-1:0]  rsp_hour_of_day,
   output logic [DAY_W-1:0]   rsp_day_of_month,
   output logic [MONTH_W-1:0] rsp_month_of_year,
   output logic [YEAR_W-1:0]  rsp_year_since_2000
);

   localparam int Q1_W = quot_width(EPOCH_W, SECS_PER_MIN);
   localparam int Q2_W = quot_width(Q1_W, MINS_PER_HOUR);
   localparam int Q3_W = quot_width(Q2_W, HOURS_PER_DAY);
   localparam int Q4_W = quot_width(Q3_W, DAYS_PER_CYCLE);

   logic              d1_valid, d1_ready, d2_valid, d2_ready;
   logic              d3_valid, d3_ready, d4_valid, d4_ready;
   logic [Q1_W-1:0]   d1_quot;
   logic [Q2_W-1:0]   d2_quot;
   logic [Q3_W-1:0]   d3_quot;
   logic [Q4_W-1:0]   d4_quot;
   logic [SEC_W-1:0]  d1_rem;
   logic [MIN_W-1:0]  d2_rem;
   logic [HOUR_W-1:0] d3_rem;
   logic [DIC_W-1:0]  d4_rem;
   time_type          d1_side, d2_side, d3_side, d4_side;
   time_type          side2, side3, side4, cal_side;

   ecd_div_const #(.IN_W(EPOCH_W), .DIV(SECS_PER_MIN)) u_div_sec (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_value(req_epoch_seconds), .in_side(time_type'('0)),
      .out_valid(d1_valid), .out_ready(d1_ready),
      .out_quot(d1_quot), .out_rem(d1_rem), .out_side(d1_side)
   );

   always_comb begin
      side2        = d1_side;
      side2.second = d1_rem;
   end

   ecd_div_const #(.IN_W(Q1_W), .DIV(MINS_PER_HOUR)) u_div_min (
      .clock(clock), .reset(reset),
      .in_valid(d1_valid), .in_ready(d1_ready),
      .in_value(d1_quot), .in_side(side2),
      .out_valid(d2_valid), .out_ready(d2_ready),
      .out_quot(d2_quot), .out_rem(d2_rem), .out_side(d2_side)
   );

   always_comb begin
      side3        = d2_side;
      side3.minute = d2_rem;
   end

   ecd_div_const #(.IN_W(Q2_W), .DIV(HOURS_PER_DAY)) u_div_hour (
      .clock(clock), .reset(reset),
      .in_valid(d2_valid), .in_ready(d2_ready),
      .in_value(d2_quot), .in_side(side3),
      .out_valid(d3_valid), .out_ready(d3_ready),
      .out_quot(d3_quot), .out_rem(d3_rem), .out_side(d3_side)
   );

   always_comb begin
      side4      = d3_side;
      side4.hour = d3_rem;
   end

   ecd_div_const #(.IN_W(Q3_W), .DIV(DAYS_PER_CYCLE)) u_div_cycle (
      .clock(clock), .reset(reset),
      .in_valid(d3_valid), .in_ready(d3_ready),
      .in_value(d3_quot), .in_side(side4),
      .out_valid(d4_valid), .out_ready(d4_ready),
      .out_quot(d4_quot), .out_rem(d4_rem), .out_side(d4_side)
   );

   ecd_calendar #(.CYCLE_W(Q4_W)) u_calendar (
      .clock(clock), .reset(reset),
      .in_valid(d4_valid), .in_ready(d4_ready),
      .in_cycles(d4_quot), .in_day_in_cycle(d4_rem), .in_side(d4_side),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_side(cal_side), .out_day(rsp_day_of_month),
      .out_month(rsp_month_of_year), .out_year(rsp_year_since_2000)
   );

   assign rsp_second_of_minute = cal_side.second;
   assign rsp_minute_of_hour   = cal_side.minute;
   assign rsp_hour_of_day      = cal_side.hour;

   `ECD_ASSERT(a_time_range, rsp_valid |-> (rsp_second_of_minute < 6'd60) && (rsp_minute_of_hour < 6'd60) && (rsp_hour_of_day < 5'd24), "time field out of range")
   `ECD_ASSERT(a_date_range, rsp_valid |-> (rsp_day_of_month != 5'd0) && (rsp_month_of_year != 4'd0) && (rsp_month_of_year <= 4'd12), "date field out of range")
   `ECD_ASSERT(a_common_feb, rsp_valid && (rsp_month_of_year == 4'd2) && (rsp_year_since_2000[1:0] != 2'd0) |-> (rsp_day_of_month <= 5'd28), "February too long in a common year")
   `ECD_ASSERT_RESET(a_reset_empty, reset |=> !rsp_valid, "result offered straight after reset")

endmodule

// File: tb/epoch_to_calendar_date_core_test.sv
// Self-checking testbench for epoch_to_calendar_date_core: drives seconds since 2000 and checks
// each calendar date against its own calculation, with random idling on both sides.
// Depends on ecd_pkg and the converter RTL only.
module epoch_to_calendar_date_core_test
   import ecd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned SECS_PER_DAY = SECS_PER_MIN * MINS_PER_HOUR * HOURS_PER_DAY;
   localparam int ITEMS_PER_PHASE = 400;
   localparam int BURST_ITEMS     = 40;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int DRAIN_CYCLES    = 40;
   localparam int TIMEOUT_NS      = 1000000;

   // First day of each month, counted from the start of a four-year cycle.
   localparam int unsigned CYCLE_MONTH_START [4][12] = '{
      '{   0,   31,   60,   91,  121,  152,  182,  213,  244,  274,  305,  335},
      '{ 366,  397,  425,  456,  486,  517,  547,  578,  609,  639,  670,  700},
      '{ 731,  762,  790,  821,  851,  882,  912,  943,  974, 1004, 1035, 1065},
      '{1096, 1127, 1155, 1186, 1216, 1247, 1277, 1308, 1339, 1369, 1400, 1430}
   };

   localparam logic [EPOCH_W-1:0] DIRECTED_EPOCHS [23] = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd5097599, 32'd5097600, 32'd5184000,
      32'd31622399, 32'd31622400, 32'd36719999, 32'd36720000,
      32'd94694400, 32'd126230399, 32'd126230400,
      32'd3160857600, 32'd3160944000,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
   };

   typedef struct {
      logic [SEC_W-1:0]   second;
      logic [MIN_W-1:0]   minute;
      logic [HOUR_W-1:0]  hour;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_fields_type;

   class calendar_scoreboard_type;
      date_fields_type expected_dates[$];
      int mismatches = 0;

      function date_fields_type date_of_epoch(logic [EPOCH_W-1:0] epoch);
         date_fields_type d;
         int unsigned rest;
         int unsigned cycle;
         int unsigned day_in_cycle;
         int unsigned yr;
         int unsigned mo;
         rest = epoch;
         d.second = SEC_W'(rest % SECS_PER_MIN);
         rest = rest / SECS_PER_MIN;
         d.minute = MIN_W'(rest % MINS_PER_HOUR);
         rest = rest / MINS_PER_HOUR;
         d.hour = HOUR_W'(rest % HOURS_PER_DAY);
         rest = rest / HOURS_PER_DAY;
         cycle = rest / DAYS_PER_CYCLE;
         day_in_cycle = rest % DAYS_PER_CYCLE;
         yr = 3;
         while (yr > 0 && day_in_cycle < CYCLE_MONTH_START[yr][0]) yr--;
         mo = 11;
         while (mo > 0 && day_in_cycle < CYCLE_MONTH_START[yr][mo]) mo--;
         d.day = DAY_W'(day_in_cycle - CYCLE_MONTH_START[yr][mo] + 1);
         d.month = MONTH_W'(mo + 1);
         d.year = YEAR_W'(cycle * 4 + yr);
         return d;
      endfunction

      function void note_epoch(logic [EPOCH_W-1:0] epoch);
         expected_dates.push_back(date_of_epoch(epoch));
      endfunction

      function void compare_field(string name, int unsigned expected, int unsigned actual);
         if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatches++;
         end
      endfunction

      function void check_date(date_fields_type got);
         date_fields_type want;
         if (expected_dates.size() == 0) begin
            $error("result item arrived with no item outstanding");
            mismatches++;
            return;
         end
         want = expected_dates.pop_front();
         compare_field("second_of_minute", want.second, got.second);
         compare_field("minute_of_hour", want.minute, got.minute);
         compare_field("hour_of_day", want.hour, got.hour);
         compare_field("day_of_month", want.day, got.day);
         compare_field("month_of_year", want.month, got.month);
         compare_field("year_since_2000", want.year, got.year);
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [EPOCH_W-1:0] req_epoch_seconds;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [SEC_W-1:0]   rsp_second_of_minute;
   logic [MIN_W-1:0]   rsp_minute_of_hour;
   logic [HOUR_W-1:0]  rsp_hour_of_day;
   logic [DAY_W-1:0]   rsp_day_of_month;
   logic [MONTH_W-1:0] rsp_month_of_year;
   logic [YEAR_W-1:0]  rsp_year_since_2000;

   calendar_scoreboard_type dates = new();
   date_fields_type observed_date;
   bit idling = 1'b1;
   bit hold_off_request = 1'b0;

   epoch_to_calendar_date_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_of_year    (rsp_month_of_year),
      .rsp_year_since_2000  (rsp_year_since_2000)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) dates.note_epoch(req_epoch_seconds);
         if (rsp_valid && rsp_ready) begin
            observed_date.second = rsp_second_of_minute;
            observed_date.minute = rsp_minute_of_hour;
            observed_date.hour = rsp_hour_of_day;
            observed_date.day = rsp_day_of_month;
            observed_date.month = rsp_month_of_year;
            observed_date.year = rsp_year_since_2000;
            dates.check_date(observed_date);
         end
      end
   end

   function automatic int draw_wait();
      return idling ? $urandom_range(0, 13) : 0;
   endfunction

   // Half the values lie near month and day boundaries; the rest spread over the whole range or sit near its top.
   function automatic logic [EPOCH_W-1:0] random_epoch();
      longint unsigned secs;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         secs = $urandom;
      end else if (kind < 7) begin
         secs = longint'($urandom_range(0, 29)) * DAYS_PER_CYCLE
                + CYCLE_MONTH_START[$urandom_range(0, 3)][$urandom_range(0, 11)];
         secs = secs * SECS_PER_DAY + $urandom_range(0, 119);
         if (secs >= 120) secs = secs - 60;
      end else if (kind < 9) begin
         secs = longint'($urandom_range(0, 49710)) * SECS_PER_DAY + $urandom_range(0, 119);
         if (secs >= 120) secs = secs - 60;
      end else begin
         secs = 64'hFFFF_FFFF - $urandom_range(0, 1 << 26);
      end
      if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;
      return EPOCH_W'(secs);
   endfunction

   // Called at a rising edge; returns at the edge where the item is accepted.
   task automatic send_epoch(input logic [EPOCH_W-1:0] epoch, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= epoch;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (dates.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            stall = draw_wait();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      req_valid = 1'b0;
      req_epoch_seconds = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_EPOCHS[i]) send_epoch(DIRECTED_EPOCHS[i], draw_wait());
      for (int phase = 0; phase < 4; phase++) begin
         idling = (phase != 1);
         if (phase == 2) begin
            // The receiver holds off while items keep coming, so the pipeline backs up.
            hold_off_request = 1'b1;
            repeat (BURST_ITEMS) send_epoch(random_epoch(), 0);
            wait_until_drained();
         end
         repeat (ITEMS_PER_PHASE) send_epoch(random_epoch(), draw_wait());
      end
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (dates.mismatches == 0 && dates.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: epoch_to_calendar_date_core.f
+incdir+rtl
rtl/ecd_pkg.sv
rtl/ecd_div_const.sv
rtl/ecd_calendar.sv
rtl/epoch_to_calendar_date_core.sv
tb/epoch_to_calendar_date_core_test.sv
